// ===== hw/rtl/rdcf_pkg.sv =====
// Shared types, constants and codes of the range-Doppler colormap formatter.
`timescale 1ns / 1ps
`default_nettype none

package rdcf_pkg;

  localparam int unsigned MAX_DOPPLER   = 256;
  localparam int unsigned MAX_RANGE     = 1024;
  localparam int unsigned COLOR_ENTRIES = 256;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned PWR_W      = 16;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DIFF_W     = PWR_W + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ND_REG_W   = 9;
  localparam int unsigned NR_REG_W   = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TABLE_WR    = 2'd0,
    FUNC_SAMPLE      = 2'd1,
    FUNC_FRAME_START = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DOPPLER  = 3'd0,
    CFG_NUM_RANGE    = 3'd1,
    CFG_SCALE_OFFSET = 3'd2,
    CFG_REF_LEVEL    = 3'd3,
    CFG_COLOR_GAIN   = 3'd4,
    CFG_PEAK_OVERLAY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [PWR_W-1:0] power_db;
    logic [IDX_W-1:0]        table_index;
    logic [RGB_W-1:0]        table_rgb;
    logic [ROW_W-1:0]        peak_range;
    logic [COL_W-1:0]        peak_doppler;
  } in_word_t;

  typedef struct packed {
    logic              image_kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last_of_run;
    logic              frame_done;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             dti;
    logic             overlay;
    logic             frame_done;
  } pix_meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rdcf_stream_if.sv =====
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
`default_nettype none

interface rdcf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rdcf_mod.sv =====
// Iterative remainder unit: Doppler counter and peak bin modulo the Doppler count.
`timescale 1ns / 1ps
`default_nettype none

module rdcf_mod #(
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] nd_i,
  input  logic [DW-1:0] dc_i,
  input  logic [rdcf_pkg::COL_W-1:0] pd_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] dmod_o,
  output logic [DW-1:0] pmod_o
);
  localparam int unsigned OW  = (DW > rdcf_pkg::COL_W) ? DW : rdcf_pkg::COL_W;
  localparam int unsigned SW  = OW + DW;
  localparam int unsigned CNW = $clog2(OW);

  logic           busy_q;
  logic [CNW-1:0] cnt_q;
  logic [SW-1:0]  ra_q, ra_d;
  logic [SW-1:0]  rb_q, rb_d;
  logic [SW-1:0]  div_q;

  always_comb begin
    ra_d = ra_q;
    rb_d = rb_q;
    if (ra_q >= div_q) begin
      ra_d = ra_q - div_q;
    end
    if (rb_q >= div_q) begin
      rb_d = rb_q - div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNW'(OW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNW'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // restoring remainder, one divisor multiple per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ra_q  <= SW'(dc_i);
      rb_q  <= SW'(pd_i);
      div_q <= SW'(nd_i) << (OW - 1);
    end else if (busy_q) begin
      ra_q  <= ra_d;
      rb_q  <= rb_d;
      div_q <= div_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign dmod_o = ra_d[DW-1:0];
  assign pmod_o = rb_d[DW-1:0];

`ifndef SYNTHESIS
  a_mod_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("remainder unit not busy after start");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rdcf_seq.sv =====
// Frame sequencer: range and Doppler counters, shifted column and DTI flags.
`timescale 1ns / 1ps
`default_nettype none

module rdcf_seq #(
  parameter int unsigned DW = 9,
  parameter int unsigned RW = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       smp_fire_i,
  input  logic                       frs_fire_i,
  input  logic [rdcf_pkg::ROW_W-1:0] peak_range_i,
  input  logic [rdcf_pkg::COL_W-1:0] peak_doppler_i,
  input  logic [DW-1:0]              nd_i,
  input  logic [RW-1:0]              nr_i,
  input  logic [DW-1:0]              half_i,
  input  logic                       overlay_en_i,
  input  logic                       mod_done_i,
  input  logic [DW-1:0]              dmod_i,
  input  logic [DW-1:0]              pmod_i,
  output rdcf_pkg::pix_meta_t        meta_o,
  output logic [DW-1:0]              dc_o,
  output logic [rdcf_pkg::COL_W-1:0] pd_o
);
  localparam int unsigned PW  = (RW > rdcf_pkg::ROW_W) ? RW : rdcf_pkg::ROW_W;
  localparam int unsigned CXW = ((DW + 1) > rdcf_pkg::COL_W) ? (DW + 1) : rdcf_pkg::COL_W;

  logic [RW-1:0]              rc_q;
  logic [DW-1:0]              dc_q;
  logic [rdcf_pkg::ROW_W-1:0] pr_q;
  logic [rdcf_pkg::COL_W-1:0] pd_q;
  logic [DW-1:0]              dmod_q;
  logic [DW-1:0]              pmod_q;

  logic [DW:0]    col_sum;
  logic [DW:0]    col_red;
  logic [CXW-1:0] col_x;
  logic [PW-1:0]  row_x;
  logic [RW-1:0]  rc_inc;
  logic [DW-1:0]  dc_inc;
  logic           rc_wrap;
  logic           dc_wrap;

  always_comb begin
    col_sum = {1'b0, dmod_q} + {1'b0, half_i};
    col_red = (col_sum >= {1'b0, nd_i}) ? (col_sum - {1'b0, nd_i}) : col_sum;
    col_x   = CXW'(col_red);
    row_x   = PW'(rc_q);
    rc_inc  = rc_q + RW'(1);
    dc_inc  = dc_q + DW'(1);
    rc_wrap = (rc_inc >= nr_i);
    dc_wrap = (dc_inc >= nd_i);

    meta_o.row        = row_x[rdcf_pkg::ROW_W-1:0];
    meta_o.column     = col_x[rdcf_pkg::COL_W-1:0];
    meta_o.dti        = (row_x == PW'(pr_q));
    // shifted columns match exactly when the reduced bins match
    meta_o.overlay    = overlay_en_i && (dmod_q == pmod_q);
    meta_o.frame_done = rc_wrap && dc_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= '0;
      dc_q   <= '0;
      pr_q   <= '0;
      pd_q   <= '0;
      dmod_q <= '0;
      pmod_q <= '0;
    end else if (frs_fire_i) begin
      rc_q   <= '0;
      dc_q   <= '0;
      pr_q   <= peak_range_i;
      pd_q   <= peak_doppler_i;
      dmod_q <= '0;
    end else if (smp_fire_i) begin
      if (rc_wrap) begin
        rc_q <= '0;
        if (dc_wrap) begin
          dc_q   <= '0;
          dmod_q <= '0;
        end else begin
          dc_q   <= dc_inc;
          dmod_q <= dc_inc;
        end
      end else begin
        rc_q <= rc_inc;
      end
    end else if (mod_done_i) begin
      dmod_q <= dmod_i;
      pmod_q <= pmod_i;
    end
  end

  assign dc_o = dc_q;
  assign pd_o = pd_q;

`ifndef SYNTHESIS
  a_seq_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frs_fire_i |=> (rc_q == '0) && (dc_q == '0))
    else $error("counters not cleared by frame start");

  a_seq_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done_i |=> (dmod_q < nd_i) && (pmod_q < nd_i))
    else $error("reduced bin not below Doppler count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rdcf_pipe.sv =====
// Pixel pipeline: dB scaling, colormap memory access and pixel output stage.
`timescale 1ns / 1ps
`default_nettype none

module rdcf_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic                              is_wr_i,
  input  logic signed [rdcf_pkg::PWR_W-1:0] power_db_i,
  input  logic [rdcf_pkg::IDX_W-1:0]        table_index_i,
  input  logic [rdcf_pkg::RGB_W-1:0]        table_rgb_i,
  input  rdcf_pkg::pix_meta_t               meta_i,
  input  logic signed [rdcf_pkg::PWR_W-1:0] scale_offset_i,
  input  logic signed [rdcf_pkg::PWR_W-1:0] ref_level_i,
  input  logic [rdcf_pkg::GAIN_W-1:0]       color_gain_i,
  output logic                              ready_o,
  rdcf_stream_if.source                     out_o
);
  localparam int unsigned DFW = rdcf_pkg::DIFF_W;
  localparam int unsigned PRW = (DFW - 1) + rdcf_pkg::GAIN_W;
  localparam int unsigned QW  = PRW - 16;

  // stage 1: difference
  logic                          s1_v_q;
  logic                          s1_wr_q;
  logic signed [DFW-1:0]         s1_diff_q;
  logic [rdcf_pkg::IDX_W-1:0]    s1_addr_q;
  logic [rdcf_pkg::RGB_W-1:0]    s1_rgb_q;
  rdcf_pkg::pix_meta_t           s1_meta_q;
  // stage 2: memory access
  logic                          s2_v_q;
  logic                          s2_wr_q;
  logic [rdcf_pkg::IDX_W-1:0]    s2_addr_q;
  logic [rdcf_pkg::RGB_W-1:0]    s2_rgb_q;
  rdcf_pkg::pix_meta_t           s2_meta_q;
  // stage 3: pixel out
  logic                          s3_v_q;
  logic                          phase_q;
  logic [rdcf_pkg::RGB_W-1:0]    s3_rgb_q;
  rdcf_pkg::pix_meta_t           s3_meta_q;

  logic [rdcf_pkg::RGB_W-1:0] color_mem [rdcf_pkg::COLOR_ENTRIES];

  logic signed [DFW-1:0]      diff;
  logic                       s1_pos;
  logic [PRW-1:0]             prod;
  logic [QW-1:0]              quot;
  logic [rdcf_pkg::IDX_W-1:0] cidx;
  logic                       last;
  logic                       out_fire;
  logic                       s3_ready;
  logic                       s2_ready;
  logic                       s1_ready;

  assign diff = DFW'(power_db_i) + DFW'(scale_offset_i) - DFW'(ref_level_i);

  always_comb begin
    s1_pos = !s1_diff_q[DFW-1] && (s1_diff_q != '0);
    prod   = PRW'(s1_diff_q[DFW-2:0]) * PRW'(color_gain_i);
    quot   = prod[PRW-1:16];
    if (!s1_pos) begin
      cidx = '0;
    end else if (|quot[QW-1:rdcf_pkg::IDX_W]) begin
      cidx = '1;
    end else begin
      cidx = quot[rdcf_pkg::IDX_W-1:0];
    end
  end

  assign last     = !s3_meta_q.dti || phase_q;
  assign out_fire = s3_v_q && out_o.ready;
  assign s3_ready = !s3_v_q || (out_fire && last);
  assign s2_ready = !s2_v_q || s2_wr_q || s3_ready;
  assign s1_ready = !s1_v_q || s2_ready;
  assign ready_o  = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= push_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q  <= s2_v_q && !s2_wr_q;
        phase_q <= 1'b0;
      end else if (out_fire) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_wr_q   <= is_wr_i;
      s1_diff_q <= diff;
      s1_addr_q <= table_index_i;
      s1_rgb_q  <= table_rgb_i;
      s1_meta_q <= meta_i;
    end
    if (s2_ready) begin
      s2_wr_q   <= s1_wr_q;
      s2_addr_q <= s1_wr_q ? s1_addr_q : cidx;
      s2_rgb_q  <= s1_rgb_q;
      s2_meta_q <= s1_meta_q;
    end
  end

  // table writes travel with the samples, so reads and writes stay in order
  always_ff @(posedge clk_i) begin
    if (s2_v_q && s2_wr_q) begin
      color_mem[s2_addr_q] <= s2_rgb_q;
    end
    if (s3_ready && s2_v_q && !s2_wr_q) begin
      s3_rgb_q  <= color_mem[s2_addr_q];
      s3_meta_q <= s2_meta_q;
    end
  end

  assign out_o.valid = s3_v_q;

  always_comb begin
    out_o.word.image_kind  = phase_q;
    out_o.word.row         = s3_meta_q.row;
    out_o.word.column      = s3_meta_q.column;
    out_o.word.blue        = (phase_q && s3_meta_q.overlay) ? '1 : s3_rgb_q[7:0];
    out_o.word.green       = s3_rgb_q[15:8];
    out_o.word.red         = s3_rgb_q[23:16];
    out_o.word.last_of_run = last;
    out_o.word.frame_done  = s3_meta_q.frame_done;
  end

`ifndef SYNTHESIS
  a_pipe_phase_dti: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (s3_v_q && s3_meta_q.dti))
    else $error("second word without DTI pixel");

  a_pipe_second_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last) |=> (s3_v_q && phase_q && $stable(s3_rgb_q)))
    else $error("DTI word lost after image word");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/range_doppler_colormap_formatter.sv =====
// Top level of the range-Doppler colormap formatter.
//
// in_i takes one word per handshake: func 0 writes a colormap entry, func 1 is a
// power sample (Doppler bin outer, range inner), func 2 starts a frame and
// latches the peak row and bin, func 3 is dropped. cfg_i writes the registers
// num_doppler, num_range, scale_offset, ref_level, color_gain, peak_overlay at
// indexes 0 to 5; it is always ready. It is to be written only while the block
// idles; the block itself does not enforce this. out_o gives one image pixel
// per sample, followed by a DTI pixel when the sample sits on the peak range row.
// A sample passes the difference, memory access and pixel out stages in that
// order. Throughput: one sample per cycle while out_o is ready and nothing
// holds the input; a sample with a DTI pixel holds the output for its second
// word. After a frame start or a register write the input is held off while
// the remainder unit reduces the Doppler counter and peak bin modulo the count.
// Reset clears counters and peaks and sets the registers to their defaults;
// colormap entries hold nothing until written. A stalled output holds its word
// and the three pipeline stages fill before in_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module range_doppler_colormap_formatter #(
  parameter int unsigned MAX_DOPPLER = rdcf_pkg::MAX_DOPPLER,
  parameter int unsigned MAX_RANGE   = rdcf_pkg::MAX_RANGE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rdcf_stream_if.sink   in_i,
  rdcf_stream_if.source out_o,
  rdcf_stream_if.sink   cfg_i
);
  localparam int unsigned DW  = $clog2(MAX_DOPPLER + 1);
  localparam int unsigned RW  = $clog2(MAX_RANGE + 1);
  localparam int unsigned NDW = (DW > rdcf_pkg::ND_REG_W) ? DW : rdcf_pkg::ND_REG_W;
  localparam int unsigned NRW = (RW > rdcf_pkg::NR_REG_W) ? RW : rdcf_pkg::NR_REG_W;

  logic [rdcf_pkg::ND_REG_W-1:0]    num_doppler_q;
  logic [rdcf_pkg::NR_REG_W-1:0]    num_range_q;
  logic signed [rdcf_pkg::PWR_W-1:0] scale_offset_q;
  logic signed [rdcf_pkg::PWR_W-1:0] ref_level_q;
  logic [rdcf_pkg::GAIN_W-1:0]      color_gain_q;
  logic                             peak_overlay_q;
  logic                             start_q;

  logic [NDW-1:0] nd_sat;
  logic [NRW-1:0] nr_sat;
  logic [DW-1:0]  nd_eff;
  logic [RW-1:0]  nr_eff;
  logic [DW-1:0]  half;

  logic cfg_fire;
  logic in_fire;
  logic smp_fire;
  logic frs_fire;
  logic wr_fire;
  logic pipe_ready;

  logic                       mod_busy;
  logic                       mod_done;
  logic [DW-1:0]              dmod;
  logic [DW-1:0]              pmod;
  logic [DW-1:0]              dc;
  logic [rdcf_pkg::COL_W-1:0] pd;
  rdcf_pkg::pix_meta_t        meta;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_doppler_q  <= rdcf_pkg::ND_REG_W'(256);
      num_range_q    <= rdcf_pkg::NR_REG_W'(1024);
      scale_offset_q <= '0;
      ref_level_q    <= '0;
      color_gain_q   <= rdcf_pkg::GAIN_W'(1638);
      peak_overlay_q <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_i.word.index)
        rdcf_pkg::CFG_NUM_DOPPLER: begin
          num_doppler_q <= cfg_i.word.value[rdcf_pkg::ND_REG_W-1:0];
        end
        rdcf_pkg::CFG_NUM_RANGE: begin
          num_range_q <= cfg_i.word.value[rdcf_pkg::NR_REG_W-1:0];
        end
        rdcf_pkg::CFG_SCALE_OFFSET: begin
          scale_offset_q <= cfg_i.word.value;
        end
        rdcf_pkg::CFG_REF_LEVEL: begin
          ref_level_q <= cfg_i.word.value;
        end
        rdcf_pkg::CFG_COLOR_GAIN: begin
          color_gain_q <= cfg_i.word.value;
        end
        rdcf_pkg::CFG_PEAK_OVERLAY: begin
          peak_overlay_q <= cfg_i.word.value[0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective counts: Doppler even in 2..MAX_DOPPLER, range in 1..MAX_RANGE
  always_comb begin
    nd_sat = (NDW'(num_doppler_q) > NDW'(MAX_DOPPLER)) ? NDW'(MAX_DOPPLER)
                                                        : NDW'(num_doppler_q);
    nd_sat[0] = 1'b0;
    if (nd_sat < NDW'(2)) begin
      nd_sat = NDW'(2);
    end
    nr_sat = (NRW'(num_range_q) > NRW'(MAX_RANGE)) ? NRW'(MAX_RANGE)
                                                    : NRW'(num_range_q);
    if (nr_sat == '0) begin
      nr_sat = NRW'(1);
    end
    nd_eff = nd_sat[DW-1:0];
    nr_eff = nr_sat[RW-1:0];
    half   = nd_eff >> 1;
  end

  assign in_i.ready = pipe_ready && !start_q && !mod_busy;
  assign in_fire    = in_i.valid && in_i.ready;
  assign smp_fire   = in_fire && (in_i.word.func == rdcf_pkg::FUNC_SAMPLE);
  assign frs_fire   = in_fire && (in_i.word.func == rdcf_pkg::FUNC_FRAME_START);
  assign wr_fire    = in_fire && (in_i.word.func == rdcf_pkg::FUNC_TABLE_WR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_fire || frs_fire;
    end
  end

  rdcf_mod #(
    .DW(DW)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .nd_i   (nd_eff),
    .dc_i   (dc),
    .pd_i   (pd),
    .busy_o (mod_busy),
    .done_o (mod_done),
    .dmod_o (dmod),
    .pmod_o (pmod)
  );

  rdcf_seq #(
    .DW(DW),
    .RW(RW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .smp_fire_i    (smp_fire),
    .frs_fire_i    (frs_fire),
    .peak_range_i  (in_i.word.peak_range),
    .peak_doppler_i(in_i.word.peak_doppler),
    .nd_i          (nd_eff),
    .nr_i          (nr_eff),
    .half_i        (half),
    .overlay_en_i  (peak_overlay_q),
    .mod_done_i    (mod_done),
    .dmod_i        (dmod),
    .pmod_i        (pmod),
    .meta_o        (meta),
    .dc_o          (dc),
    .pd_o          (pd)
  );

  rdcf_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (smp_fire || wr_fire),
    .is_wr_i       (wr_fire),
    .power_db_i    (in_i.word.power_db),
    .table_index_i (in_i.word.table_index),
    .table_rgb_i   (in_i.word.table_rgb),
    .meta_i        (meta),
    .scale_offset_i(scale_offset_q),
    .ref_level_i   (ref_level_q),
    .color_gain_i  (color_gain_q),
    .ready_o       (pipe_ready),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_range_doppler_colormap_formatter.sv =====
// Self-checking testbench for the range-Doppler colormap formatter.
`timescale 1ns / 1ps

module tb_range_doppler_colormap_formatter;
  import rdcf_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_DROP = 2'd3;
  localparam int unsigned WATCHDOG   = 1000;
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned RAND_ITEMS = 1600;

  logic clk_i;
  logic rst_ni;

  rdcf_stream_if #(.T(in_word_t))  in_if ();
  rdcf_stream_if #(.T(out_word_t)) out_if ();
  rdcf_stream_if #(.T(cfg_word_t)) cfg_if ();

  range_doppler_colormap_formatter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // predictor state and register copies
  logic [RGB_W-1:0]        cmap [COLOR_ENTRIES];
  int unsigned             rng_cnt = 0;
  int unsigned             dop_cnt = 0;
  int unsigned             pk_rng  = 0;
  int unsigned             pk_dop  = 0;
  logic [ND_REG_W-1:0]     reg_nd      = 9'd256;
  logic [NR_REG_W-1:0]     reg_nr      = 11'd1024;
  logic signed [PWR_W-1:0] reg_offset  = '0;
  logic signed [PWR_W-1:0] reg_ref     = '0;
  logic [GAIN_W-1:0]       reg_gain    = 16'd1638;
  logic                    reg_overlay = 1'b0;

  out_word_t   pixel_q [$];
  out_word_t   want_px;
  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  bit          src_idle    = 1'b1;
  bit          snk_idle    = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_doppler();
    int unsigned n;
    n = reg_nd;
    if (n > MAX_DOPPLER) n = MAX_DOPPLER;
    n[0] = 1'b0;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic int unsigned eff_range();
    int unsigned n;
    n = reg_nr;
    if (n > MAX_RANGE) n = MAX_RANGE;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] color_index(input logic signed [PWR_W-1:0] pw);
    longint d;
    longint q;
    d = longint'(pw) + longint'(reg_offset) - longint'(reg_ref);
    if (d <= 0) return '0;
    q = (d * longint'(reg_gain)) >>> 16;
    if (q > COLOR_ENTRIES - 1) q = COLOR_ENTRIES - 1;
    return q[IDX_W-1:0];
  endfunction

  function automatic void predict_pixels(input in_word_t w);
    int unsigned nd, nr, half, col, pcol, row;
    logic [RGB_W-1:0] rgb;
    out_word_t px;
    bit dti, done;
    case (w.func)
      FUNC_TABLE_WR: cmap[w.table_index] = w.table_rgb;
      FUNC_FRAME_START: begin
        pk_rng  = w.peak_range;
        pk_dop  = w.peak_doppler;
        rng_cnt = 0;
        dop_cnt = 0;
      end
      FUNC_SAMPLE: begin
        nd   = eff_doppler();
        nr   = eff_range();
        half = nd / 2;
        col  = (dop_cnt + half) % nd;
        pcol = (pk_dop + half) % nd;
        rgb  = cmap[color_index(w.power_db)];
        row  = rng_cnt;
        dti  = (rng_cnt == pk_rng);
        done = 1'b0;
        rng_cnt++;
        if (rng_cnt >= nr) begin
          rng_cnt = 0;
          dop_cnt++;
          if (dop_cnt >= nd) begin
            dop_cnt = 0;
            done    = 1'b1;
          end
        end
        px.image_kind  = 1'b0;
        px.row         = ROW_W'(row);
        px.column      = COL_W'(col);
        px.blue        = rgb[7:0];
        px.green       = rgb[15:8];
        px.red         = rgb[23:16];
        px.last_of_run = !dti;
        px.frame_done  = done;
        pixel_q.push_back(px);
        if (dti) begin
          px.image_kind  = 1'b1;
          px.blue        = (reg_overlay && pcol == col) ? 8'hFF : rgb[7:0];
          px.last_of_run = 1'b1;
          pixel_q.push_back(px);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  function automatic in_word_t rand_word(input logic [FUNC_W-1:0] f);
    in_word_t w;
    w.func         = f;
    w.power_db     = PWR_W'($urandom);
    w.table_index  = IDX_W'($urandom);
    w.table_rgb    = RGB_W'($urandom);
    w.peak_range   = ROW_W'($urandom);
    w.peak_doppler = COL_W'($urandom);
    return w;
  endfunction

  // output side: random stall before each word while snk_idle is set
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = snk_idle ? $urandom_range(0, 11) : 0;
      @(negedge clk_i);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected word %p", out_if.word);
        err_count++;
      end else begin
        want_px = pixel_q.pop_front();
        check_field("image_kind", want_px.image_kind, out_if.word.image_kind);
        check_field("row", want_px.row, out_if.word.row);
        check_field("column", want_px.column, out_if.word.column);
        check_field("blue", want_px.blue, out_if.word.blue);
        check_field("green", want_px.green, out_if.word.green);
        check_field("red", want_px.red, out_if.word.red);
        check_field("last_of_run", want_px.last_of_run, out_if.word.last_of_run);
        check_field("frame_done", want_px.frame_done, out_if.word.frame_done);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.word  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_pixels(w);
  endtask

  task automatic send_sample(input logic [PWR_W-1:0] pw);
    in_word_t w;
    w = rand_word(FUNC_SAMPLE);
    w.power_db = pw;
    send_word(w);
  endtask

  task automatic send_frame_start(input logic [ROW_W-1:0] pr, input logic [COL_W-1:0] pd);
    in_word_t w;
    w = rand_word(FUNC_FRAME_START);
    w.peak_range   = pr;
    w.peak_doppler = pd;
    send_word(w);
  endtask

  task automatic send_table_entry(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
    in_word_t w;
    w = rand_word(FUNC_TABLE_WR);
    w.table_index = idx;
    w.table_rgb   = rgb;
    send_word(w);
  endtask

  task automatic send_random_frame_start();
    logic [ROW_W-1:0] pr;
    logic [COL_W-1:0] pd;
    pr = ($urandom_range(0, 9) < 8) ? ROW_W'($urandom_range(0, eff_range() - 1))
                                    : ROW_W'($urandom);
    pd = ($urandom_range(0, 9) < 7) ? COL_W'($urandom_range(0, eff_doppler() - 1))
                                    : COL_W'($urandom);
    send_frame_start(pr, pd);
  endtask

  // drain all pixels, then give words that produce nothing time to finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.word.index  <= idx;
    cfg_if.word.value  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_NUM_DOPPLER:  reg_nd      = v[ND_REG_W-1:0];
      CFG_NUM_RANGE:    reg_nr      = v[NR_REG_W-1:0];
      CFG_SCALE_OFFSET: reg_offset  = v;
      CFG_REF_LEVEL:    reg_ref     = v;
      CFG_COLOR_GAIN:   reg_gain    = v;
      CFG_PEAK_OVERLAY: reg_overlay = v[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_colormap_load();
    for (int i = 0; i < COLOR_ENTRIES; i++) begin
      logic [RGB_W-1:0] rgb;
      rgb = RGB_W'($urandom);
      if (i == 0) rgb = '0;
      if (i == COLOR_ENTRIES - 1) rgb = '1;
      send_table_entry(IDX_W'(i), rgb);
    end
  endtask

  // register values straight out of reset
  task automatic test_reset_defaults();
    send_frame_start(10'd1, 8'd0);
    send_sample(16'h0000);
    send_sample(16'h7FFF);
    send_sample(16'h0A00);
  endtask

  // 2 x 2 frame, DTI on row 1, overlay on the second Doppler bin only
  task automatic test_directed_frame();
    wait_idle();
    write_reg(CFG_NUM_DOPPLER, 16'd2);
    write_reg(CFG_NUM_RANGE, 16'd2);
    write_reg(CFG_SCALE_OFFSET, 16'h0000);
    write_reg(CFG_REF_LEVEL, 16'h0000);
    write_reg(CFG_COLOR_GAIN, 16'hFFFF);
    write_reg(CFG_PEAK_OVERLAY, 16'd1);
    send_frame_start(10'd1, 8'd1);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'h7FFF);
    send_sample(16'h0002);
    send_word(rand_word(FUNC_DROP));
    send_frame_start(10'd0, 8'hFF);
    send_sample(16'h0100);
  endtask

  task automatic test_register_limits();
    wait_idle();
    write_reg(CFG_NUM_DOPPLER, 16'd0);
    write_reg(CFG_NUM_RANGE, 16'd0);
    write_reg(CFG_SCALE_OFFSET, 16'h7FFF);
    write_reg(CFG_REF_LEVEL, 16'h8000);
    write_reg(CFG_COLOR_GAIN, 16'h0000);
    write_reg(CFG_PEAK_OVERLAY, 16'd0);
    send_frame_start(10'd0, 8'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_idle();
    write_reg(CFG_NUM_DOPPLER, 16'h01FF);
    write_reg(CFG_NUM_RANGE, 16'h07FF);
    write_reg(CFG_SCALE_OFFSET, 16'h8000);
    write_reg(CFG_REF_LEVEL, 16'h7FFF);
    write_reg(CFG_COLOR_GAIN, 16'hFFFF);
    write_reg(CFG_PEAK_OVERLAY, 16'd1);
    send_frame_start(10'd0, 8'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
  endtask

  // counters left beyond a count that has just shrunk
  task automatic test_counter_wrap();
    wait_idle();
    write_reg(CFG_NUM_DOPPLER, 16'd4);
    write_reg(CFG_NUM_RANGE, 16'd1);
    send_frame_start(10'h3FF, 8'd200);
    repeat (3) send_sample(PWR_W'($urandom));
    wait_idle();
    write_reg(CFG_NUM_DOPPLER, 16'd3);
    send_sample(PWR_W'($urandom));
    wait_idle();
    write_reg(CFG_NUM_RANGE, 16'd1024);
    send_frame_start(10'd2, 8'd0);
    repeat (3) send_sample(PWR_W'($urandom));
    wait_idle();
    write_reg(CFG_NUM_RANGE, 16'd2);
    send_sample(PWR_W'($urandom));
  endtask

  task automatic test_random_frames();
    int unsigned done_items, phase_len, pick, v;
    int base, span, pw;
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      wait_idle();
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) v = 2 * $urandom_range(1, 8);
      else if (pick == 6) v = $urandom_range(0, 511);
      else if (pick == 7) v = 256;
      else v = 2 * $urandom_range(9, 64);
      write_reg(CFG_NUM_DOPPLER, CFG_DATA_W'(v));
      pick = $urandom_range(0, 9);
      if (pick < 7) v = $urandom_range(1, 12);
      else if (pick == 7) v = $urandom_range(13, 64);
      else if (pick == 8) v = $urandom_range(0, 2047);
      else v = 1;
      write_reg(CFG_NUM_RANGE, CFG_DATA_W'(v));
      if ($urandom_range(0, 1)) write_reg(CFG_SCALE_OFFSET, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) write_reg(CFG_REF_LEVEL, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) begin
        v = $urandom_range(0, 1) ? $urandom_range(300, 4000) : $urandom_range(0, 65535);
        write_reg(CFG_COLOR_GAIN, CFG_DATA_W'(v));
      end
      if ($urandom_range(0, 1)) write_reg(CFG_PEAK_OVERLAY, CFG_DATA_W'($urandom_range(0, 1)));
      send_random_frame_start();
      done_items++;
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_table_entry(IDX_W'($urandom), RGB_W'($urandom));
          done_items++;
        end else if (pick < 5) begin
          send_word(rand_word(FUNC_DROP));
        end else if (pick < 8) begin
          send_random_frame_start();
          done_items++;
        end else if (pick < 9) begin
          wait_idle();
        end else begin
          if ($urandom_range(0, 1)) begin
            pw = $urandom;
          end else begin
            base = int'(reg_ref) - int'(reg_offset);
            span = (reg_gain == 0) ? 512 : (255 * 65536) / int'(reg_gain) + 8;
            if (span > 60000) span = 60000;
            pw = base - 4 + int'($urandom_range(0, span));
          end
          send_sample(pw[PWR_W-1:0]);
          done_items++;
          if (rng_cnt == 0 && dop_cnt == 0 && $urandom_range(0, 1)) begin
            send_random_frame_start();
            done_items++;
          end
        end
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.word   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.word  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_colormap_load();
    test_reset_defaults();
    test_directed_frame();
    test_register_limits();
    test_counter_wrap();
    test_random_frames();
    wait_idle();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
